>>> rtl/pol_pkg.sv
package pol_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  localparam int POS_W  = 5;
  localparam int RVAL_W = 32;
  localparam int CNTO_W = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] AT_START = 2'd0;
  localparam logic [1:0] AT_END   = 2'd1;
  localparam logic [1:0] AT_POS   = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } pol_cmd_t;

endpackage

>>> rtl/pol_cell.sv
module pol_cell #(
  parameter int DATA_W = 32,
  parameter int IDX_W  = 4,
  parameter int IDX    = 0
) (
  input  logic                clk,
  input  pol_pkg::pol_cmd_t   cmd,
  input  logic [IDX_W-1:0]    k,
  input  logic [DATA_W-1:0]   value,
  input  logic [DATA_W-1:0]   left,
  input  logic [DATA_W-1:0]   right,
  output logic [DATA_W-1:0]   data,
  output logic [DATA_W-1:0]   rd_data
);
  import pol_pkg::*;

  localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins && (ME > k)) begin
      data_nxt = left;
    end else if (cmd.ins && (ME == k)) begin
      data_nxt = value;
    end else if (cmd.del && (ME >= k)) begin
      data_nxt = right;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (ME == k) ? data_r : '0;

endmodule

>>> rtl/pol_ctrl.sv
module pol_ctrl #(
  parameter int DEPTH = 16,
  parameter int CNT_W = $clog2(DEPTH + 1),
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     fire,
  input  logic [1:0]               op,
  input  logic [1:0]               where_sel,
  input  logic [pol_pkg::POS_W-1:0] position,
  input  logic [CNT_W-1:0]         cnt,
  output pol_pkg::pol_cmd_t        cmd,
  output logic [IDX_W-1:0]         k,
  output logic [CNT_W-1:0]         cnt_nxt,
  output logic [1:0]               status
);
  import pol_pkg::*;

  localparam int CMP_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] lim;
  logic [CMP_W-1:0] p;
  logic [CMP_W-1:0] pm1;

  assign pos_w = CMP_W'(position);
  assign lim   = (op == OP_INSERT) ? CMP_W'(cnt) + CMP_W'(1) : CMP_W'(cnt);

  always_comb begin
    case (where_sel)
      AT_START: p = (lim != '0) ? CMP_W'(1) : '0;
      AT_END:   p = lim;
      AT_POS:   p = ((pos_w != '0) && (pos_w <= lim)) ? pos_w : '0;
      default:  p = '0;
    endcase
  end

  assign pm1 = p - CMP_W'(1);
  assign k   = pm1[IDX_W-1:0];

  always_comb begin
    cmd     = '0;
    status  = ST_INVALID;
    cnt_nxt = cnt;
    case (op)
      OP_INSERT: begin
        if (p != '0) begin
          if (cnt == CNT_W'(DEPTH)) begin
            status = ST_FULL;
          end else begin
            cmd.ins = fire;
            status  = ST_DONE;
            cnt_nxt = cnt + CNT_W'(1);
          end
        end
      end
      OP_DELETE: begin
        if (p != '0) begin
          cmd.del = fire;
          status  = ST_DONE;
          cnt_nxt = cnt - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (p != '0) begin
          cmd.rd = 1'b1;
          status = ST_DONE;
        end
      end
      default: begin
        status = ST_INVALID;
      end
    endcase
  end

endmodule

>>> rtl/positional_ordered_list.sv
// positional_ordered_list
//
// A bounded ordered list of up to DEPTH values, held in a row of cells.
// Input channel (in_valid / in_stall): one operation per transfer, op selects
// insert, delete or read, where_sel selects start, end or in_position.
// Result channel (out_valid / out_stall): exactly one result per input
// transfer, carrying read_value, count after the operation and status.
// A result is registered at the edge that takes the input transfer. The list
// takes one operation per cycle while in_stall is low; every cell shifts
// or holds at that edge, so each insert or delete completes at once.
// The read path is a one-hot select over all cells feeding the result
// register.
// When the receiver stalls with a result waiting, in_stall is raised and the
// list holds until that result is taken; the stalled result does not change.
// Reset clears the entry count and the result valid flag; cell contents are
// left as they are and are never read before being written.
module positional_ordered_list #(
  parameter int DEPTH  = pol_pkg::DEPTH_DEF,
  parameter int DATA_W = pol_pkg::DATA_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [1:0]                  in_where_sel,
  input  logic [pol_pkg::POS_W-1:0]   in_position,
  input  logic [31:0]                 in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pol_pkg::RVAL_W-1:0]  out_read_value,
  output logic [pol_pkg::CNTO_W-1:0]  out_count,
  output logic [1:0]                  out_status
);
  import pol_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              fire;
  pol_cmd_t          cmd;
  logic [IDX_W-1:0]  k;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [CNT_W-1:0]  cnt_calc;
  logic [1:0]        status;

  logic [DATA_W+31:0] vext;
  logic [DATA_W-1:0]  val;
  logic [DATA_W-1:0]  cell_data [DEPTH];
  logic [DATA_W-1:0]  cell_rd   [DEPTH];
  logic [DATA_W-1:0]  rd_sel;
  logic [DATA_W+31:0] rext;
  logic [CNT_W+CNTO_W-1:0] cext;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [RVAL_W-1:0]     rval_r;
  logic [CNTO_W-1:0]     cnto_r;
  logic [1:0]            status_r;

  assign in_stall = out_valid_r && out_stall;
  assign fire     = in_valid && !in_stall;

  assign vext = {{DATA_W{1'b0}}, in_value};
  assign val  = vext[DATA_W-1:0];

  pol_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .fire      (fire),
    .op        (in_op),
    .where_sel (in_where_sel),
    .position  (in_position),
    .cnt       (cnt_r),
    .cmd       (cmd),
    .k         (k),
    .cnt_nxt   (cnt_calc),
    .status    (status)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = val;
    end else begin : g_mid
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_inner
      assign right = cell_data[i+1];
    end
    pol_cell #(
      .DATA_W (DATA_W),
      .IDX_W  (IDX_W),
      .IDX    (i)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .k       (k),
      .value   (val),
      .left    (left),
      .right   (right),
      .data    (cell_data[i]),
      .rd_data (cell_rd[i])
    );
  end

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
    if (!cmd.rd) begin
      rd_sel = '0;
    end
  end

  assign rext = {32'b0, rd_sel};
  assign cext = {{CNTO_W{1'b0}}, cnt_calc};

  assign cnt_nxt       = fire ? cnt_calc : cnt_r;
  assign out_valid_nxt = fire ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rval_r   <= rext[RVAL_W-1:0];
      cnto_r   <= cext[CNTO_W-1:0];
      status_r <= status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = rval_r;
  assign out_count      = cnto_r;
  assign out_status     = status_r;

endmodule
